@@ rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg - shared types and constants of the open addressing hash table
// field widths, operation codes, slot marks and sequencer states
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int MODE_W     = 3;
    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int VAL_W      = 64;
    localparam int CFG_W      = 6;
    localparam int MARK_W     = 2;

    // beat layouts
    localparam int IN_DATA_W  = KEY_W + HASH_W + VAL_W;
    localparam int OUT_DATA_W = VAL_W;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_W-1:0] MAX_FILL_RST = CFG_W'(48);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_SET      = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_GET      = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_REMOVE   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CONTAINS = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_CLEAR    = MODE_W'(4);

    // slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY = MARK_W'(0);
    localparam logic [MARK_W-1:0] MARK_USED  = MARK_W'(1);
    localparam logic [MARK_W-1:0] MARK_TOMB  = MARK_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE,
        S_CLEAR
    } t_state;

endpackage

@@ rtl/open_addressing_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top - linear probing hash table with tombstones
// set, get, remove, contains and clear over a table of SLOTS slots
// ----------------------------------------------------------------------------
// flow: an item steps through S_PROBE, one slot read per cycle through the
//   slot memory read port, and then S_DONE; when SLOTS is not a power of two
//   S_HASH first finds the home slot (reciprocal multiply, then remainder).
//   clear empties every slot in turn in S_CLEAR
// throughput: one item at a time, next input beat taken in the cycle after the
//   result is placed in the output register
// reset: synchronous active low; then a pass empties every slot before the
//   first input beat is taken; max_fill returns to 48
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
    parameter int SLOTS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [oaht_pkg::IN_DATA_W-1:0]       i_s_tdata,  // key_id, key_hash, value
    input  logic [oaht_pkg::MODE_W-1:0]          i_s_tuser,  // mode
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [oaht_pkg::OUT_DATA_W-1:0]      o_m_tdata,  // out_value
    output logic [oaht_pkg::OUT_USER_W-1:0]      o_m_tuser,  // hit, status
    // max_fill register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [oaht_pkg::CFG_W-1:0]           i_cfg_data   // max_fill
);

    localparam int AW = $clog2(SLOTS);
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [AW-1:0] LAST_IDX  = AW'(SLOTS - 1);
    localparam logic [AW:0]   SLOTS_V   = (AW+1)'(SLOTS);
    localparam logic [AW:0]   LAST_ISSUE = (AW+1)'(SLOTS - 1);
    // hash mod SLOTS: quotient = (hash * RECIP) >> QSH, exact for 32-bit hashes
    localparam int QSH = oaht_pkg::HASH_W + AW;
    localparam int QW  = oaht_pkg::HASH_W + 1 - AW;
    localparam logic [oaht_pkg::HASH_W:0] RECIP =
        (oaht_pkg::HASH_W+1)'(((64'd1 << QSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);

    // slot memories
    logic [oaht_pkg::MARK_W-1:0] mem_mark [SLOTS];
    logic [oaht_pkg::KEY_W-1:0]  mem_key  [SLOTS];
    logic [oaht_pkg::VAL_W-1:0]  mem_data [SLOTS];

    // sequencer and item registers
    oaht_pkg::t_state r_state, n_state;
    logic [oaht_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [oaht_pkg::KEY_W-1:0]      r_key, n_key;
    logic [oaht_pkg::HASH_W-1:0]     r_hash, n_hash;
    logic [oaht_pkg::VAL_W-1:0]      r_val, n_val;
    logic [QW-1:0]                   r_quo, n_quo;
    logic                            r_hash_step, n_hash_step;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [AW:0]                     r_issued, n_issued;
    logic                            r_have_tomb, n_have_tomb;
    logic [AW-1:0]                   r_tomb_idx, n_tomb_idx;
    logic [oaht_pkg::CFG_W-1:0]      r_fill, n_fill;
    logic [oaht_pkg::CFG_W-1:0]      r_max_fill;
    logic [AW-1:0]                   r_clr_idx, n_clr_idx;
    logic                            r_clr_resp, n_clr_resp;

    // registered slot read
    logic                            r_rd_live, r_rd_last;
    logic [AW-1:0]                   r_rd_idx;
    logic [oaht_pkg::MARK_W-1:0]     r_rd_mark;
    logic [oaht_pkg::KEY_W-1:0]      r_rd_key;
    logic [oaht_pkg::VAL_W-1:0]      r_rd_data;

    // pending result and output register
    logic                            r_res_hit, n_res_hit;
    logic                            r_res_status, n_res_status;
    logic [oaht_pkg::VAL_W-1:0]      r_res_value, n_res_value;
    logic                            r_out_valid, r_out_hit, r_out_status;
    logic [oaht_pkg::VAL_W-1:0]      r_out_value;

    // slot write port
    logic                            w_we_mark, w_we_key, w_we_data;
    logic [AW-1:0]                   w_wa;
    logic [oaht_pkg::MARK_W-1:0]     w_wmark;

    // probe compare and hash reduction
    logic          w_issue, w_used, w_tomb, w_empty, w_match, w_stop;
    logic          w_eff_have, w_free, w_free_new, w_fill_full;
    logic [AW-1:0] w_eff_tidx, w_free_idx, w_next_idx;
    logic [2*oaht_pkg::HASH_W:0] w_prod;
    logic [AW-1:0] w_qs, w_rem;
    logic          w_out_free;

    assign o_s_tready  = (r_state == oaht_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_value;
    assign o_m_tuser   = {r_out_status, r_out_hit};

    assign w_out_free = !r_out_valid || i_m_tready;

    // reciprocal multiply, top bits hold the quotient
    assign w_prod = {{(oaht_pkg::HASH_W+1){1'b0}}, r_hash} *
                    {{oaht_pkg::HASH_W{1'b0}}, RECIP};
    // remainder is below SLOTS, so only the low bits are needed
    assign w_qs  = r_quo[AW-1:0] * SLOTS_LO;
    assign w_rem = r_hash[AW-1:0] - w_qs;

    // slot check on the read data of the previous cycle
    assign w_issue    = (r_issued != SLOTS_V);
    assign w_next_idx = (r_idx == LAST_IDX) ? '0 : (r_idx + 1'b1);
    assign w_used     = (r_rd_mark == oaht_pkg::MARK_USED);
    assign w_tomb     = (r_rd_mark == oaht_pkg::MARK_TOMB);
    assign w_empty    = !w_used && !w_tomb;
    assign w_match    = w_used && (r_rd_key == r_key);
    assign w_stop     = r_rd_live && (w_match || w_empty || r_rd_last);
    // first tombstone, counting the slot under check
    assign w_eff_have = r_have_tomb || w_tomb;
    assign w_eff_tidx = r_have_tomb ? r_tomb_idx : r_rd_idx;
    assign w_free     = !w_match && (w_empty || w_eff_have);
    assign w_free_new = !w_eff_have;
    assign w_free_idx = w_eff_have ? w_eff_tidx : r_rd_idx;
    assign w_fill_full = ({1'b0, r_fill} + 1'b1) > {1'b0, r_max_fill};

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_hash       = r_hash;
        n_val        = r_val;
        n_quo        = r_quo;
        n_hash_step  = r_hash_step;
        n_idx        = r_idx;
        n_issued     = r_issued;
        n_have_tomb  = r_have_tomb;
        n_tomb_idx   = r_tomb_idx;
        n_fill       = r_fill;
        n_clr_idx    = r_clr_idx;
        n_clr_resp   = r_clr_resp;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        w_we_mark    = 1'b0;
        w_we_key     = 1'b0;
        w_we_data    = 1'b0;
        w_wa         = r_rd_idx;
        w_wmark      = oaht_pkg::MARK_USED;

        unique case (r_state)
            oaht_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode       = i_s_tuser;
                    n_key        = i_s_tdata[oaht_pkg::KEY_W-1:0];
                    n_hash       = i_s_tdata[oaht_pkg::KEY_W +: oaht_pkg::HASH_W];
                    n_val        = i_s_tdata[oaht_pkg::KEY_W + oaht_pkg::HASH_W +: oaht_pkg::VAL_W];
                    n_hash_step  = 1'b0;
                    n_idx        = i_s_tdata[oaht_pkg::KEY_W +: AW];
                    n_issued     = '0;
                    n_have_tomb  = 1'b0;
                    n_res_hit    = 1'b0;
                    n_res_status = 1'b0;
                    n_res_value  = '0;
                    if (i_s_tuser == oaht_pkg::MODE_SET || i_s_tuser == oaht_pkg::MODE_GET ||
                        i_s_tuser == oaht_pkg::MODE_REMOVE ||
                        i_s_tuser == oaht_pkg::MODE_CONTAINS) begin
                        n_state = IS_POW2 ? oaht_pkg::S_PROBE : oaht_pkg::S_HASH;
                    end else if (i_s_tuser == oaht_pkg::MODE_CLEAR) begin
                        n_state    = oaht_pkg::S_CLEAR;
                        n_clr_idx  = '0;
                        n_clr_resp = 1'b1;
                        n_fill     = '0;
                    end else begin
                        n_state = oaht_pkg::S_DONE;
                    end
                end
            end
            oaht_pkg::S_HASH: begin
                // quotient first, remainder in the following cycle
                if (!r_hash_step) begin
                    n_quo       = w_prod[QSH +: QW];
                    n_hash_step = 1'b1;
                end else begin
                    n_idx   = w_rem;
                    n_state = oaht_pkg::S_PROBE;
                end
            end
            oaht_pkg::S_PROBE: begin
                if (w_issue) begin
                    n_idx    = w_next_idx;
                    n_issued = r_issued + 1'b1;
                end
                if (r_rd_live && w_tomb && !r_have_tomb) begin
                    n_have_tomb = 1'b1;
                    n_tomb_idx  = r_rd_idx;
                end
                if (w_stop) begin
                    n_state = oaht_pkg::S_DONE;
                    unique case (r_mode)
                        oaht_pkg::MODE_SET: begin
                            if (w_match) begin
                                w_we_data = 1'b1;
                            end else if (w_free && !(w_free_new && w_fill_full)) begin
                                w_we_mark = 1'b1;
                                w_we_key  = 1'b1;
                                w_we_data = 1'b1;
                                w_wa      = w_free_idx;
                                n_res_hit = 1'b1;
                                if (w_free_new) begin
                                    n_fill = r_fill + 1'b1;
                                end
                            end else begin
                                n_res_status = 1'b1;
                            end
                        end
                        oaht_pkg::MODE_GET: begin
                            if (w_match) begin
                                n_res_hit   = 1'b1;
                                n_res_value = r_rd_data;
                            end
                        end
                        oaht_pkg::MODE_REMOVE: begin
                            if (w_match) begin
                                w_we_mark = 1'b1;
                                w_wmark   = oaht_pkg::MARK_TOMB;
                                n_res_hit = 1'b1;
                            end
                        end
                        default: begin
                            n_res_hit = w_match;
                        end
                    endcase
                end
            end
            oaht_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_CLEAR: begin
                w_we_mark = 1'b1;
                w_wa      = r_clr_idx;
                w_wmark   = oaht_pkg::MARK_EMPTY;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_clr_idx = '0;
                    n_state   = r_clr_resp ? oaht_pkg::S_DONE : oaht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oaht_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= oaht_pkg::S_CLEAR;   // emptying pass after reset
            r_clr_idx  <= '0;
            r_clr_resp <= 1'b0;
            r_fill     <= '0;
            r_max_fill <= oaht_pkg::MAX_FILL_RST;
            r_rd_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_clr_resp <= n_clr_resp;
            r_fill     <= n_fill;
            r_rd_live  <= (r_state == oaht_pkg::S_PROBE) &&
                          (n_state == oaht_pkg::S_PROBE) && w_issue;
            if (i_cfg_valid) begin
                r_max_fill <= i_cfg_data;
            end
            if (r_state == oaht_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and probe bookkeeping
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_val        <= n_val;
        r_quo        <= n_quo;
        r_hash_step  <= n_hash_step;
        r_idx        <= n_idx;
        r_issued     <= n_issued;
        r_have_tomb  <= n_have_tomb;
        r_tomb_idx   <= n_tomb_idx;
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_rd_idx     <= r_idx;
        r_rd_last    <= (r_issued == LAST_ISSUE);
        if (r_state == oaht_pkg::S_DONE && w_out_free) begin
            r_out_hit    <= r_res_hit;
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    // slot memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we_mark) begin
            mem_mark[w_wa] <= w_wmark;
        end
        if (w_we_key) begin
            mem_key[w_wa] <= r_key;
        end
        if (w_we_data) begin
            mem_data[w_wa] <= r_val;
        end
        r_rd_mark <= mem_mark[r_idx];
        r_rd_key  <= mem_key[r_idx];
        r_rd_data <= mem_data[r_idx];
    end

    // fill count only steps up by one or drops to zero on clear
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |->
            (r_fill == oaht_pkg::CFG_W'($past(r_fill) + 1'b1) || r_fill == '0))
        else $error("fill count moved by more than one");

    // no input beat while the slots are being emptied
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oaht_pkg::S_CLEAR) |-> !o_s_tready)
        else $error("input taken during clearing pass");

    // a checked slot read only ever belongs to an ongoing probe
    a_read_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_live |-> (r_state == oaht_pkg::S_PROBE))
        else $error("slot read checked outside a probe");

endmodule

@@ tb/oaht_table_checker.sv @@
// ----------------------------------------------------------------------------
// oaht_table_checker - shadow hash table and reply comparison
// mirrors slot marks, keys, data and fill count from the input and config
// beats, and compares every reply beat with the oldest predicted reply
// ----------------------------------------------------------------------------
module oaht_table_checker #(
    parameter int SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [oaht_pkg::IN_DATA_W-1:0]  i_s_tdata,   // key_id, key_hash, value
    input  logic [oaht_pkg::MODE_W-1:0]     i_s_tuser,   // mode
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [oaht_pkg::OUT_DATA_W-1:0] i_m_tdata,   // out_value
    input  logic [oaht_pkg::OUT_USER_W-1:0] i_m_tuser,   // hit, status
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [oaht_pkg::CFG_W-1:0]      i_cfg_data,  // max_fill
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic                       hit;
        logic [oaht_pkg::VAL_W-1:0] out_value;
        logic                       status;
    } t_table_reply;

    typedef enum {PR_MATCH, PR_FREE, PR_NONE} t_probe_kind;

    logic [oaht_pkg::MARK_W-1:0] slot_mark [SLOTS];
    logic [oaht_pkg::KEY_W-1:0]  slot_key  [SLOTS];
    logic [oaht_pkg::VAL_W-1:0]  slot_data [SLOTS];
    int                          fill_count;
    int                          max_fill;
    int                          fails = 0;
    t_table_reply                reply_q [$];

    // linear probe from the home slot, first tombstone wins for a free slot
    function automatic t_probe_kind walk(input logic [oaht_pkg::KEY_W-1:0] key,
                                         input logic [oaht_pkg::HASH_W-1:0] hash,
                                         output int at);
        int  idx;
        int  tomb;
        bit  have_tomb;
        idx       = int'(hash % 32'(SLOTS));
        tomb      = 0;
        have_tomb = 0;
        at        = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_mark[idx] == oaht_pkg::MARK_USED) begin
                if (slot_key[idx] == key) begin
                    at = idx;
                    return PR_MATCH;
                end
            end else if (slot_mark[idx] == oaht_pkg::MARK_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1;
                    tomb      = idx;
                end
            end else begin
                at = have_tomb ? tomb : idx;
                return PR_FREE;
            end
            idx = (idx + 1 == SLOTS) ? 0 : idx + 1;
        end
        if (have_tomb) begin
            at = tomb;
            return PR_FREE;
        end
        return PR_NONE;
    endfunction

    function automatic t_table_reply table_op(input logic [oaht_pkg::MODE_W-1:0] mode,
                                              input logic [oaht_pkg::KEY_W-1:0]  key,
                                              input logic [oaht_pkg::HASH_W-1:0] hash,
                                              input logic [oaht_pkg::VAL_W-1:0]  val);
        t_table_reply r;
        t_probe_kind  kind;
        int           at;
        r = '0;
        case (mode)
            oaht_pkg::MODE_SET: begin
                kind = walk(key, hash, at);
                if (kind == PR_MATCH) begin
                    slot_data[at] = val;
                end else if (kind == PR_FREE) begin
                    if (slot_mark[at] == oaht_pkg::MARK_EMPTY &&
                        fill_count + 1 > max_fill) begin
                        r.status = 1'b1;
                    end else begin
                        if (slot_mark[at] == oaht_pkg::MARK_EMPTY) fill_count++;
                        slot_mark[at] = oaht_pkg::MARK_USED;
                        slot_key[at]  = key;
                        slot_data[at] = val;
                        r.hit         = 1'b1;
                    end
                end else begin
                    r.status = 1'b1;
                end
            end
            oaht_pkg::MODE_GET: begin
                if (walk(key, hash, at) == PR_MATCH) begin
                    r.hit       = 1'b1;
                    r.out_value = slot_data[at];
                end
            end
            oaht_pkg::MODE_REMOVE: begin
                if (walk(key, hash, at) == PR_MATCH) begin
                    slot_mark[at] = oaht_pkg::MARK_TOMB;
                    r.hit         = 1'b1;
                end
            end
            oaht_pkg::MODE_CONTAINS: begin
                if (walk(key, hash, at) == PR_MATCH) r.hit = 1'b1;
            end
            oaht_pkg::MODE_CLEAR: begin
                foreach (slot_mark[i]) slot_mark[i] = oaht_pkg::MARK_EMPTY;
                fill_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_table_reply want;
        t_table_reply got;
        if (!i_rst_n) begin
            foreach (slot_mark[i]) begin
                slot_mark[i] = oaht_pkg::MARK_EMPTY;
                slot_key[i]  = '0;
                slot_data[i] = '0;
            end
            fill_count = 0;
            max_fill   = int'(oaht_pkg::MAX_FILL_RST);
            reply_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_fill = int'(i_cfg_data);
            if (i_s_tvalid && i_s_tready) begin
                reply_q.push_back(table_op(
                    i_s_tuser,
                    i_s_tdata[oaht_pkg::KEY_W-1:0],
                    i_s_tdata[oaht_pkg::KEY_W+oaht_pkg::HASH_W-1:oaht_pkg::KEY_W],
                    i_s_tdata[oaht_pkg::IN_DATA_W-1:oaht_pkg::KEY_W+oaht_pkg::HASH_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.hit       = i_m_tuser[0];
                got.status    = i_m_tuser[1];
                got.out_value = i_m_tdata;
                if (reply_q.size() == 0) begin
                    $error("reply beat with no request outstanding");
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fails++;
                    end
                    if (got.out_value !== want.out_value) begin
                        $error("out_value: expected %h, got %h",
                               want.out_value, got.out_value);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= reply_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/open_addressing_hash_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top_tb - regression for the linear probing table
// directed probes around wrap, tombstones and refusal, then random phases of
// set/get/remove/contains/clear traffic under several max_fill settings, with
// random gaps on the request side and random stalls on the reply side
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top_tb;

    localparam int SLOTS     = 64;
    localparam int POOL_SIZE = 24;

    // every input starts at a known value
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic [oaht_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;   // key_id, key_hash, value
    logic [oaht_pkg::MODE_W-1:0]     i_s_tuser   = '0;   // mode
    logic                            i_m_tready  = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [oaht_pkg::CFG_W-1:0]      i_cfg_data  = '0;   // max_fill
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [oaht_pkg::OUT_DATA_W-1:0] o_m_tdata;          // out_value
    logic [oaht_pkg::OUT_USER_W-1:0] o_m_tuser;          // hit, status
    logic                            o_cfg_ready;

    int fail_count;
    int pending;

    // no idling on either side while set
    bit steady     = 1'b0;
    int ready_hold = 0;

    // key pool for the random part, each key keeps its own hash
    logic [oaht_pkg::KEY_W-1:0]  pool_key  [POOL_SIZE];
    logic [oaht_pkg::HASH_W-1:0] pool_hash [POOL_SIZE];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    open_addressing_hash_table_top #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    oaht_table_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // reply side: hold tready high or low for random stretches,
    // mostly short stalls with a few long ones
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady) begin
            i_m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 65) begin
            i_m_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            i_m_tready <= 1'b0;
            ready_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                       : $urandom_range(10, 40);
        end
    end

    // request-side gap before the next beat
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one request beat; tvalid stays high across back-to-back beats
    task automatic push_op(input logic [oaht_pkg::MODE_W-1:0] mode,
                           input logic [oaht_pkg::KEY_W-1:0]  key,
                           input logic [oaht_pkg::HASH_W-1:0] hash,
                           input logic [oaht_pkg::VAL_W-1:0]  val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {val, hash, key};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // stop requests and wait for every outstanding reply, then let the
    // block settle back to idle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // register write only with the table idle
    task automatic write_max_fill(input logic [oaht_pkg::CFG_W-1:0] fill);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fill;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                          plan_fill [6];
        int                          plan_len  [6];
        int                          r;
        int                          k;
        int                          sent;
        logic [5:0]                  base;
        logic [oaht_pkg::HASH_W-1:0] h;

        // reset held low from time zero, released on a clock edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, max_fill at its reset value ----
        // lookups into an empty table
        push_op(oaht_pkg::MODE_CONTAINS, 32'h1, 32'h0, 64'h0);
        push_op(oaht_pkg::MODE_GET, 32'h1, 32'h0, 64'h0);
        // key handle zero, insert then overwrite
        push_op(oaht_pkg::MODE_SET, 32'h0, 32'h0, '1);
        push_op(oaht_pkg::MODE_GET, 32'h0, 32'h0, 64'h0);
        push_op(oaht_pkg::MODE_SET, 32'h0, 32'h0, 64'h0);
        // home slot at the top end, second key wraps past slot zero
        push_op(oaht_pkg::MODE_SET, '1, '1, 64'hA5A5_A5A5_A5A5_A5A5);
        push_op(oaht_pkg::MODE_SET, 32'h8000_0001, '1, 64'h5A5A_5A5A_5A5A_5A5A);
        push_op(oaht_pkg::MODE_GET, 32'h8000_0001, '1, 64'h0);
        // remove leaves a tombstone, second remove misses
        push_op(oaht_pkg::MODE_REMOVE, 32'h0, 32'h0, 64'h0);
        push_op(oaht_pkg::MODE_REMOVE, 32'h0, 32'h0, 64'h0);
        // probe walks past the tombstone
        push_op(oaht_pkg::MODE_CONTAINS, 32'h8000_0001, '1, 64'h0);
        // new key lands in the tombstone
        push_op(oaht_pkg::MODE_SET, 32'h1234_5678, 32'h0, 64'hDEAD_BEEF_0123_4567);
        push_op(oaht_pkg::MODE_GET, 32'h1234_5678, 32'h0, 64'h0);
        // unknown modes change nothing
        push_op(oaht_pkg::MODE_W'(5), $urandom, $urandom, {$urandom, $urandom});
        push_op(oaht_pkg::MODE_W'(6), $urandom, $urandom, {$urandom, $urandom});
        push_op(oaht_pkg::MODE_W'(7), 32'h1234_5678, 32'h0, '1);
        push_op(oaht_pkg::MODE_CLEAR, 32'h0, 32'h0, 64'h0);
        push_op(oaht_pkg::MODE_CONTAINS, '1, '1, 64'h0);

        // max fill zero refuses any insert into an empty slot
        write_max_fill(oaht_pkg::CFG_W'(0));
        push_op(oaht_pkg::MODE_SET, 32'h7, 32'h7, 64'h7);
        push_op(oaht_pkg::MODE_GET, 32'h7, 32'h7, 64'h0);

        // max fill two: a full table still takes a key into a tombstone
        write_max_fill(oaht_pkg::CFG_W'(2));
        push_op(oaht_pkg::MODE_SET, 32'hA, 32'h3, 64'h1);
        push_op(oaht_pkg::MODE_SET, 32'hB, 32'h4, 64'h2);
        push_op(oaht_pkg::MODE_SET, 32'hC, 32'h5, 64'h3);
        push_op(oaht_pkg::MODE_REMOVE, 32'hA, 32'h3, 64'h0);
        push_op(oaht_pkg::MODE_SET, 32'hC, 32'h3, 64'h4);
        push_op(oaht_pkg::MODE_SET, 32'hB, 32'h4, 64'h5);
        push_op(oaht_pkg::MODE_SET, 32'hD, 32'h9, 64'h6);
        push_op(oaht_pkg::MODE_CLEAR, 32'h0, 32'h0, 64'h0);

        // ---- random phases ----
        plan_fill = '{63, 1, $urandom_range(2, 62), 0, 48, 63};
        plan_len  = '{140, 60, 140, 40, 140, 140};
        foreach (plan_fill[p]) begin
            write_max_fill(oaht_pkg::CFG_W'(plan_fill[p]));
            steady = (p % 3 == 2);
            // fresh key pool, half the phases crowd the home slots together
            base = 6'($urandom);
            foreach (pool_key[i]) begin
                pool_key[i] = $urandom;
                h = $urandom;
                if (p % 2 == 0) h[5:0] = 6'(base + $urandom_range(0, 7));
                pool_hash[i] = h;
            end
            if ($urandom_range(0, 1) == 1) begin
                push_op(oaht_pkg::MODE_CLEAR, $urandom, $urandom, 64'h0);
            end
            sent = 0;
            while (sent < plan_len[p]) begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, POOL_SIZE - 1);
                if (r < 38) begin
                    push_op(oaht_pkg::MODE_SET, pool_key[k], pool_hash[k],
                            {$urandom, $urandom});
                end else if (r < 62) begin
                    push_op(oaht_pkg::MODE_GET, pool_key[k], pool_hash[k],
                            {$urandom, $urandom});
                end else if (r < 76) begin
                    push_op(oaht_pkg::MODE_REMOVE, pool_key[k], pool_hash[k],
                            {$urandom, $urandom});
                end else if (r < 90) begin
                    push_op(oaht_pkg::MODE_CONTAINS, pool_key[k], pool_hash[k],
                            {$urandom, $urandom});
                end else if (r < 93) begin
                    push_op(oaht_pkg::MODE_CLEAR, $urandom, $urandom, {$urandom, $urandom});
                end else if (r < 95) begin
                    // answered by the block with no table change, not counted
                    push_op(oaht_pkg::MODE_W'($urandom_range(5, 7)), $urandom, $urandom,
                            {$urandom, $urandom});
                    sent--;
                end else begin
                    // stray key with a random hash
                    push_op(oaht_pkg::MODE_W'($urandom_range(0, 3)), $urandom, $urandom,
                            {$urandom, $urandom});
                end
                sent++;
            end
        end

        // drain, then keep the clock running for stray beats
        wait_drained();
        repeat (SLOTS + 16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("open_addressing_hash_table_top regression: pass");
        end else begin
            $display("open_addressing_hash_table_top regression: fail");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20000000;
        $display("open_addressing_hash_table_top regression: fail");
        $finish;
    end

endmodule
